@@ src/dbq_pkg.sv @@
`timescale 1ns / 1ps
// dbq_pkg: shared types and constants of the degree bucket queue
// payload structs of both channels, operation codes and sequencer states
// depends on nothing
package dbq_pkg;

	localparam int VERTEX_W = 10;
	localparam int DEGREE_W = 7;
	localparam int KIND_W   = 2;

	// operation codes carried in the kind field
	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DECR   = 2'd2;

	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [VERTEX_W-1:0] vertex;
		logic [DEGREE_W-1:0] degree;
	} dbq_in_t;

	typedef struct packed {
		logic [DEGREE_W-1:0] max_degree;
		logic [VERTEX_W-1:0] top_vertex;
		logic                top_valid;
	} dbq_out_t;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EVAL,
		ST_UNL2,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_RELINK,
		ST_LINK_WR,
		ST_LINK_FIX,
		ST_DONE
	} dbq_state_t;

endpackage

@@ src/degree_bucket_queue.sv @@
`timescale 1ns / 1ps
// degree_bucket_queue: vertices kept in degree buckets, reports the top bucket
// uses dbq_pkg (types, codes, states) and dbq_ram (vertex and bucket memories)
//
// usage
// - input channel in_valid/in_ready/in_item: one beat is one operation
//   (insert with degree, remove, decrement) on one vertex
// - output channel out_valid/out_ready/out_item: exactly one result beat per
//   input beat, in order: highest non-empty degree and the head vertex of
//   that bucket, top_valid low when every bucket is empty
// - one operation is worked at a time by a sequencer around two memories:
//   per-vertex {degree, next, prev} and per-bucket head. unlink and relink
//   writes share the vertex memory write port, and when the top bucket
//   empties the sequencer examines the buckets below the old top in turn
// - the result sits in an output register; the next beat is accepted while
//   it waits, but that item's result holds the sequencer until out_ready
// - after reset a clearing pass zeroes all degrees and empties all buckets;
//   in_ready stays low until it ends
// - vertex numbers at or above NUM_VERTICES and kind 3 change nothing
module degree_bucket_queue
	import dbq_pkg::*;
#(
	parameter int NUM_VERTICES = 1024,
	parameter int MAX_DEGREE   = 64
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  dbq_in_t  in_item,
	output logic     out_valid,
	input  logic     out_ready,
	output dbq_out_t out_item
);

	// vertex index, degree and bucket index widths
	localparam int VW      = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
	localparam int DW      = $clog2(MAX_DEGREE + 1);
	localparam int BW      = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
	localparam int CLR_LEN = (NUM_VERTICES > MAX_DEGREE) ? NUM_VERTICES : MAX_DEGREE;
	localparam int CW      = (CLR_LEN > 1) ? $clog2(CLR_LEN) : 1;

	// list pointer: nil flag plus vertex index
	typedef struct packed {
		logic          nil;
		logic [VW-1:0] idx;
	} link_t;

	typedef struct packed {
		logic [DW-1:0] deg;
		link_t         next;
		link_t         prev;
	} vrec_t;

	localparam link_t NIL_LINK   = '{nil: 1'b1, idx: '0};
	localparam vrec_t MASK_ALL   = '{deg: '1, next: '1, prev: '1};
	localparam vrec_t MASK_DEG   = '{deg: '1, next: '0, prev: '0};
	localparam vrec_t MASK_NEXT  = '{deg: '0, next: '1, prev: '0};
	localparam vrec_t MASK_PREV  = '{deg: '0, next: '0, prev: '1};

	// bucket of degree x lives at address x-1
	function automatic logic [BW-1:0] bidx(input logic [DW-1:0] x);
		logic [DW-1:0] t;
		t = x - DW'(1);
		return t[BW-1:0];
	endfunction

	dbq_state_t state_q, state_d;

	logic [CW-1:0] clr_q;
	logic [1:0]    kind_q;
	logic [VW-1:0] v_q;
	logic [DW-1:0] degin_q;
	logic [DW-1:0] e_q;        // degree the vertex ends with
	link_t         n_q, p_q;   // unlinked vertex neighbors
	link_t         old_q;      // former bucket head on relink
	logic [DW-1:0] top_q;      // highest non-empty degree
	logic [VW-1:0] head_q;     // head of the top bucket
	logic          out_valid_q;
	dbq_out_t      out_item_q;

	// memory ports
	logic          vr_we;
	logic [VW-1:0] vr_waddr, vr_raddr;
	vrec_t         vr_wmask, vr_wdata, vr_rdata;
	logic          bk_we;
	logic [BW-1:0] bk_waddr, bk_raddr;
	link_t         bk_wdata, bk_rdata;

	// input decode
	logic [31:0]   vin32, degin32, sat32, clr32;
	logic [VW-1:0] v_in;
	logic          in_range, kind_ok;

	// evaluation of the read vertex record
	logic [DW-1:0] ev_e;
	logic          ev_live, ev_scan, ev_newhead;

	// result forming
	logic [31:0]   top32, head32;
	dbq_out_t      res;

	assign vin32    = 32'(in_item.vertex);
	assign v_in     = vin32[VW-1:0];
	assign in_range = vin32 < 32'(NUM_VERTICES);
	assign kind_ok  = (in_item.kind == KIND_INSERT) || (in_item.kind == KIND_REMOVE) ||
	                  (in_item.kind == KIND_DECR);
	assign degin32  = 32'(in_item.degree);
	// insert degree saturates to the top bucket
	assign sat32    = (degin32 > 32'(MAX_DEGREE)) ? 32'(MAX_DEGREE) : degin32;
	assign clr32    = 32'(clr_q);

	always_comb begin
		case (kind_q)
			KIND_INSERT: ev_e = degin_q;
			KIND_DECR:   ev_e = vr_rdata.deg - DW'(1);
			default:     ev_e = '0;
		endcase
	end

	// nothing to do when the vertex is unlinked and stays unlinked
	assign ev_live    = (vr_rdata.deg != '0) || ((kind_q == KIND_INSERT) && (degin_q != '0));
	// top bucket loses its only member
	assign ev_scan    = (vr_rdata.deg != '0) && vr_rdata.prev.nil && vr_rdata.next.nil &&
	                    (vr_rdata.deg == top_q);
	// top bucket loses its head but keeps members
	assign ev_newhead = (vr_rdata.deg != '0) && vr_rdata.prev.nil && !vr_rdata.next.nil &&
	                    (vr_rdata.deg == top_q);

	// sequencer state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory control
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		vr_we    = 1'b0;
		vr_waddr = v_q;
		vr_wmask = '0;
		vr_wdata = '0;
		vr_raddr = v_in;
		bk_we    = 1'b0;
		bk_waddr = bidx(e_q);
		bk_wdata = NIL_LINK;
		bk_raddr = bidx(e_q);
		case (state_q)
			ST_CLEAR: begin
				vr_we    = clr32 < 32'(NUM_VERTICES);
				vr_waddr = clr_q[VW-1:0];
				vr_wmask = MASK_ALL;
				vr_wdata = '{deg: '0, next: NIL_LINK, prev: NIL_LINK};
				bk_we    = clr32 < 32'(MAX_DEGREE);
				bk_waddr = clr_q[BW-1:0];
				bk_wdata = NIL_LINK;
				if (clr_q == CW'(CLR_LEN - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = (in_range && kind_ok) ? ST_EVAL : ST_DONE;
				end
			end
			ST_EVAL: begin
				if (!ev_live) begin
					state_d = ST_DONE;
				end else if (vr_rdata.deg != '0) begin
					if (vr_rdata.prev.nil) begin
						// vertex was bucket head: successor becomes head
						bk_we    = 1'b1;
						bk_waddr = bidx(vr_rdata.deg);
						bk_wdata = vr_rdata.next;
						vr_we    = !vr_rdata.next.nil;
						vr_waddr = vr_rdata.next.idx;
						vr_wmask = MASK_PREV;
						vr_wdata.prev = NIL_LINK;
						if (ev_scan && (vr_rdata.deg != DW'(1))) begin
							state_d = ST_SCAN_RD;
						end else begin
							state_d = ST_RELINK;
						end
					end else begin
						vr_we    = 1'b1;
						vr_waddr = vr_rdata.prev.idx;
						vr_wmask = MASK_NEXT;
						vr_wdata.next = vr_rdata.next;
						state_d  = vr_rdata.next.nil ? ST_RELINK : ST_UNL2;
					end
				end else begin
					state_d = ST_RELINK;
				end
			end
			ST_UNL2: begin
				vr_we    = 1'b1;
				vr_waddr = n_q.idx;
				vr_wmask = MASK_PREV;
				vr_wdata.prev = p_q;
				state_d  = ST_RELINK;
			end
			ST_SCAN_RD: begin
				bk_raddr = bidx(top_q);
				state_d  = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (!bk_rdata.nil || (top_q == DW'(1))) begin
					state_d = ST_RELINK;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_RELINK: begin
				if (e_q == '0) begin
					vr_we    = 1'b1;
					vr_wmask = MASK_DEG;
					state_d  = ST_DONE;
				end else begin
					bk_raddr = bidx(e_q);
					state_d  = ST_LINK_WR;
				end
			end
			ST_LINK_WR: begin
				bk_we    = 1'b1;
				bk_wdata = '{nil: 1'b0, idx: v_q};
				vr_we    = 1'b1;
				vr_wmask = MASK_ALL;
				vr_wdata = '{deg: e_q, next: bk_rdata, prev: NIL_LINK};
				state_d  = bk_rdata.nil ? ST_DONE : ST_LINK_FIX;
			end
			ST_LINK_FIX: begin
				vr_we    = 1'b1;
				vr_waddr = old_q.idx;
				vr_wmask = MASK_PREV;
				vr_wdata.prev = '{nil: 1'b0, idx: v_q};
				state_d  = ST_DONE;
			end
			ST_DONE: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers: clear counter and tracked maximum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			top_q <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: clr_q <= clr_q + CW'(1);
				ST_EVAL: begin
					if (ev_live && ev_scan) begin
						top_q <= vr_rdata.deg - DW'(1);
					end
				end
				ST_SCAN_CHK: begin
					if (bk_rdata.nil) begin
						top_q <= top_q - DW'(1);
					end
				end
				ST_LINK_WR: begin
					if (e_q >= top_q) begin
						top_q <= e_q;
					end
				end
				default: ;
			endcase
		end
	end

	// operation payload registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				kind_q  <= in_item.kind;
				v_q     <= v_in;
				degin_q <= sat32[DW-1:0];
			end
			ST_EVAL: begin
				n_q <= vr_rdata.next;
				p_q <= vr_rdata.prev;
				e_q <= ev_e;
				if (ev_newhead) begin
					head_q <= vr_rdata.next.idx;
				end
			end
			ST_SCAN_CHK: begin
				if (!bk_rdata.nil) begin
					head_q <= bk_rdata.idx;
				end
			end
			ST_LINK_WR: begin
				old_q <= bk_rdata;
				if (e_q >= top_q) begin
					head_q <= v_q;
				end
			end
			default: ;
		endcase
	end

	// result from the tracked maximum, masked to the port widths
	assign top32          = 32'(top_q);
	assign head32         = 32'(head_q);
	assign res.max_degree = top32[DEGREE_W-1:0];
	assign res.top_valid  = top_q != '0;
	assign res.top_vertex = (top_q != '0) ? head32[VERTEX_W-1:0] : '0;

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == ST_DONE) && (!out_valid_q || out_ready)) begin
			out_item_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// per-vertex degree and list links
	dbq_ram #(
		.WIDTH($bits(vrec_t)),
		.DEPTH(NUM_VERTICES)
	) u_vertex_ram (
		.clk   (clk),
		.we    (vr_we),
		.waddr (vr_waddr),
		.wmask (vr_wmask),
		.wdata (vr_wdata),
		.raddr (vr_raddr),
		.rdata (vr_rdata)
	);

	// per-degree bucket heads
	dbq_ram #(
		.WIDTH($bits(link_t)),
		.DEPTH(MAX_DEGREE)
	) u_bucket_ram (
		.clk   (clk),
		.we    (bk_we),
		.waddr (bk_waddr),
		.wmask ({$bits(link_t){1'b1}}),
		.wdata (bk_wdata),
		.raddr (bk_raddr),
		.rdata (bk_rdata)
	);

endmodule

@@ src/dbq_ram.sv @@
`timescale 1ns / 1ps
// dbq_ram: generic single-clock ram, one write port with bit mask, one read port
// read data is registered, read during write returns old data
// depends on nothing
module dbq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wmask,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= (mem[waddr] & ~wmask) | (wdata & wmask);
		end
		rdata <= mem[raddr];
	end

endmodule

@@ src/dbq_checker.sv @@
`timescale 1ns / 1ps
// dbq_checker: port-level assertions for the degree bucket queue
// uses dbq_pkg payload types, bound to degree_bucket_queue below
module dbq_checker
	import dbq_pkg::*;
(
	input logic     clk,
	input logic     arst_n,
	input logic     in_valid,
	input logic     in_ready,
	input dbq_in_t  in_item,
	input logic     out_valid,
	input logic     out_ready,
	input dbq_out_t out_item
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result beat changed while stalled");

	// one operation in flight: ready drops after an accepted beat
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("beat accepted while an operation was in flight");

	// empty queue reports a zero maximum
	a_empty_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.top_valid |-> out_item.max_degree == '0)
		else $error("nonzero maximum with no top vertex");

	// empty queue reports vertex zero
	a_empty_vertex: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.top_valid |-> out_item.top_vertex == '0)
		else $error("top vertex set with no valid top");

endmodule

bind degree_bucket_queue dbq_checker u_dbq_checker (.*);

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for degree_bucket_queue
// drives operation beats with bursts and gaps, stalls the result side, predicts every result
// depends on dbq_pkg and degree_bucket_queue from src
module testbench;
	import dbq_pkg::*;

	localparam int N_VERT    = 1024;
	localparam int MAX_DEG   = 64;
	localparam int CYC_LIMIT = 1000000;
	localparam int TAIL_CYC  = 160;
	localparam int N_RANDOM  = 1380;
	localparam int POOL_SIZE = 40;
	localparam logic [KIND_W-1:0] KIND_NOP = 2'd3;

	typedef struct {
		dbq_in_t beat;
		bit      drain_first;
	} pending_op_t;

	logic     clk       = 1'b0;
	logic     arst_n    = 1'b0;
	logic     in_valid  = 1'b0;
	logic     in_ready;
	dbq_in_t  in_item   = '0;
	logic     out_valid;
	logic     out_ready = 1'b0;
	dbq_out_t out_item;

	// operations waiting to be driven, and predicted results waiting to come back
	pending_op_t pending_ops[$];
	dbq_out_t    expected_tops[$];

	// shadow copy of the bucket lists
	int bucket_first[MAX_DEG];
	int succ[N_VERT];
	int pred[N_VERT];
	int deg_of[N_VERT];
	int top_deg;

	int mismatches = 0;
	int cycle_count = 0;
	int burst_left;
	int gap_left;
	int stall_left;
	int stall_mode;
	int pool[POOL_SIZE];

	degree_bucket_queue u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always #4 clk = ~clk;

	// ---------------------------------------------------------------
	// bucket list model
	// ---------------------------------------------------------------

	// put v at the head of bucket d-1, raising the top if needed
	function automatic void attach_vertex(int v, int d);
		int old_head;
		old_head = bucket_first[d-1];
		if (d > top_deg) begin
			top_deg = d;
		end
		bucket_first[d-1] = v;
		pred[v] = -1;
		succ[v] = old_head;
		if (old_head >= 0) begin
			pred[old_head] = v;
		end
	endfunction

	// take v out of bucket d-1; an emptied top bucket walks the top downward
	function automatic void detach_vertex(int v, int d);
		int p;
		int n;
		p = pred[v];
		n = succ[v];
		if (p < 0) begin
			bucket_first[d-1] = n;
		end else begin
			succ[p] = n;
		end
		if (n >= 0) begin
			pred[n] = p;
		end
		if (d == top_deg && bucket_first[d-1] < 0) begin
			do begin
				top_deg--;
			end while (top_deg > 0 && bucket_first[top_deg-1] < 0);
		end
	endfunction

	// apply one operation beat and return the top report it causes
	function automatic dbq_out_t apply_op(dbq_in_t op);
		int v;
		int d;
		int nd;
		dbq_out_t rpt;
		v  = int'(op.vertex);
		d  = deg_of[v];
		nd = int'(op.degree);
		case (op.kind)
			KIND_INSERT: begin
				if (nd > MAX_DEG) begin
					nd = MAX_DEG;
				end
				if (d >= 1) begin
					detach_vertex(v, d);
				end
				deg_of[v] = nd;
				if (nd >= 1) begin
					attach_vertex(v, nd);
				end
			end
			KIND_REMOVE: begin
				if (d >= 1) begin
					detach_vertex(v, d);
					deg_of[v] = 0;
				end
			end
			KIND_DECR: begin
				if (d >= 1) begin
					detach_vertex(v, d);
					deg_of[v] = d - 1;
					if (d > 1) begin
						attach_vertex(v, d - 1);
					end
				end
			end
			default: begin
				// unused kind leaves the lists alone
			end
		endcase
		rpt.max_degree = DEGREE_W'(top_deg);
		if (top_deg > 0 && bucket_first[top_deg-1] >= 0) begin
			rpt.top_vertex = VERTEX_W'(bucket_first[top_deg-1]);
			rpt.top_valid  = 1'b1;
		end else begin
			rpt.top_vertex = '0;
			rpt.top_valid  = 1'b0;
		end
		return rpt;
	endfunction

	function automatic void queue_op(logic [KIND_W-1:0] k, int v, int d, bit drain);
		pending_op_t p;
		p.beat.kind   = k;
		p.beat.vertex = VERTEX_W'(v);
		p.beat.degree = DEGREE_W'(d);
		p.drain_first = drain;
		pending_ops.push_back(p);
	endfunction

	// ---------------------------------------------------------------
	// driver: bursts of beats with random gaps, prediction on accept
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			in_item    <= '0;
			burst_left = 0;
			gap_left   = 0;
		end else begin
			// a beat accepted on this edge: its result joins the expected queue
			if (in_valid && in_ready) begin
				expected_tops.push_back(apply_op(in_item));
			end
			if (!in_valid || in_ready) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() == 0 ||
						(pending_ops[0].drain_first && expected_tops.size() != 0)) begin
					// nothing left, or holding off until every result is back
					in_valid <= 1'b0;
				end else begin
					in_item  <= pending_ops[0].beat;
					in_valid <= 1'b1;
					pending_ops.pop_front();
					if (burst_left > 1) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
					end
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: stall pattern on out_ready, compare every result beat
	// ---------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		dbq_out_t want;
		if (!arst_n) begin
			out_ready  <= 1'b0;
			stall_left = 0;
			stall_mode = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_tops.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("unexpected result beat: max %0d vertex %0d valid %0b",
							out_item.max_degree, out_item.top_vertex, out_item.top_valid);
					end
				end else begin
					want = expected_tops.pop_front();
					if (out_item.max_degree !== want.max_degree ||
							out_item.top_vertex !== want.top_vertex ||
							out_item.top_valid !== want.top_valid) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("%s got max %0d vertex %0d valid %0b",
								$sformatf("result mismatch: exp max %0d vertex %0d valid %0b,",
									want.max_degree, want.top_vertex, want.top_valid),
								out_item.max_degree, out_item.top_vertex, out_item.top_valid);
						end
					end
				end
			end
			// stall behavior changes: a new stall mode is drawn at random periodically
			if (cycle_count % 300 == 0) begin
				stall_mode = $urandom_range(0, 2);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				if (stall_mode == 1 && $urandom_range(0, 9) < 3) begin
					stall_left = $urandom_range(1, 3);
				end else if (stall_mode == 2 && $urandom_range(0, 9) == 0) begin
					stall_left = $urandom_range(5, 24);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// watchdog
	// ---------------------------------------------------------------
	initial begin
		while (cycle_count < CYC_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL degree_bucket_queue");
		$finish;
	end

	// ---------------------------------------------------------------
	// stimulus and end of run
	// ---------------------------------------------------------------
	initial begin
		int n;
		int pick;
		int v;
		int d;
		int run;
		logic [KIND_W-1:0] k;

		for (int i = 0; i < MAX_DEG; i++) begin
			bucket_first[i] = -1;
		end
		for (int i = 0; i < N_VERT; i++) begin
			succ[i]   = -1;
			pred[i]   = -1;
			deg_of[i] = 0;
		end
		top_deg = 0;

		// directed: empty queue, ignored ops, saturation, relink, deep scan
		queue_op(KIND_NOP, 0, 0, 1'b0);            // unused kind on empty queue
		queue_op(KIND_INSERT, 5, 0, 1'b0);         // degree 0 on unlinked vertex
		queue_op(KIND_DECR, 5, 0, 1'b0);           // decrement at degree 0
		queue_op(KIND_REMOVE, 5, 0, 1'b0);         // remove at degree 0
		queue_op(KIND_INSERT, 0, 127, 1'b0);       // saturates to top degree
		queue_op(KIND_INSERT, 1023, 64, 1'b0);
		queue_op(KIND_INSERT, 3, 1, 1'b0);
		queue_op(KIND_INSERT, 4, 1, 1'b0);
		queue_op(KIND_INSERT, 1023, 2, 1'b0);      // relink of a linked vertex
		queue_op(KIND_REMOVE, 0, 0, 1'b0);         // top empties, long walk down
		queue_op(KIND_DECR, 1023, 0, 1'b0);
		queue_op(KIND_DECR, 3, 0, 1'b0);           // from degree 1 to unlinked
		queue_op(KIND_INSERT, 4, 0, 1'b0);         // degree 0 on linked vertex
		queue_op(KIND_NOP, 1023, 127, 1'b0);
		queue_op(KIND_DECR, 1023, 0, 1'b0);        // all buckets empty again
		queue_op(KIND_INSERT, 2, 3, 1'b0);
		queue_op(KIND_INSERT, 7, 3, 1'b0);
		queue_op(KIND_INSERT, 9, 3, 1'b0);
		queue_op(KIND_REMOVE, 7, 0, 1'b0);         // middle of a list
		queue_op(KIND_REMOVE, 9, 0, 1'b0);         // head of a list
		queue_op(KIND_REMOVE, 2, 0, 1'b0);
		queue_op(KIND_INSERT, 1023, 65, 1'b0);
		queue_op(KIND_DECR, 1023, 0, 1'b0);

		// working set of vertices so ops mostly hit linked entries
		pool[0] = 0;
		pool[1] = N_VERT - 1;
		for (int i = 2; i < POOL_SIZE; i++) begin
			pool[i] = $urandom_range(0, N_VERT - 1);
		end

		n = 0;
		while (n < N_RANDOM) begin
			pick = $urandom_range(0, 99);
			if (pick < 6) begin
				// peel run: a string of decrements on the working set
				run = $urandom_range(3, 10);
				for (int j = 0; j < run; j++) begin
					queue_op(KIND_DECR, pool[$urandom_range(0, POOL_SIZE - 1)],
						$urandom_range(0, 127), n == N_RANDOM / 2);
					n++;
				end
			end else begin
				v = ($urandom_range(0, 99) < 85) ? pool[$urandom_range(0, POOL_SIZE - 1)]
					: $urandom_range(0, N_VERT - 1);
				pick = $urandom_range(0, 99);
				if (pick < 70) begin
					d = $urandom_range(1, 6);
				end else if (pick < 85) begin
					d = $urandom_range(0, MAX_DEG);
				end else if (pick < 95) begin
					d = $urandom_range(MAX_DEG + 1, 127);
				end else begin
					d = 0;
				end
				pick = $urandom_range(0, 99);
				if (pick < 40) begin
					k = KIND_INSERT;
				end else if (pick < 55) begin
					k = KIND_REMOVE;
				end else if (pick < 95) begin
					k = KIND_DECR;
				end else begin
					k = KIND_NOP;
				end
				// first random beat waits for the directed part to drain
				queue_op(k, v, d, n == 0 || n == N_RANDOM / 2);
				n++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || in_valid) begin
			@(posedge clk);
		end
		while (expected_tops.size() != 0) begin
			@(posedge clk);
		end
		// catch any stray beat after the last expected one
		repeat (TAIL_CYC) @(posedge clk);

		if (mismatches == 0 && expected_tops.size() == 0) begin
			$display("PASS degree_bucket_queue");
		end else begin
			$display("FAIL degree_bucket_queue");
		end
		$finish;
	end

endmodule

@@ files.f @@
src/dbq_pkg.sv
src/dbq_ram.sv
src/degree_bucket_queue.sv
src/dbq_checker.sv
sim/testbench.sv
